>>> design/rbc_pkg.sv
// ----------------------------------------------------------------------------
// rbc_pkg
// Types and constants shared by the reference-counted block cache.
// ----------------------------------------------------------------------------
package rbc_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int BLOCK_BITS_DEF = 32;
  localparam int REF_BITS       = 8;

  typedef enum logic [2:0] {
    OP_ACQUIRE    = 3'd0,
    OP_RELEASE    = 3'd1,
    OP_WRITE_BACK = 3'd2,
    OP_DIRTY_QRY  = 3'd3,
    OP_FLUSH      = 3'd4,
    OP_MARK_DIRTY = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    K_DONE      = 3'd0,
    K_WB_REQ    = 3'd1,
    K_LOAD_REQ  = 3'd2,
    K_FULL      = 3'd3,
    K_UNDERFLOW = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_FLUSH,
    ST_EMIT,
    ST_EMIT2
  } state_t;

endpackage

>>> design/refcounted_block_cache_lru.sv
// ----------------------------------------------------------------------------
// refcounted_block_cache_lru
// Tag engine for a fully associative block cache with reference counts and
// an LRU queue of free slots.
//
// s_axis: one command per transaction (operation, block number, slot).
// m_axis: one or more results per command; tlast marks the final one.
// Each command first walks the tag array one slot a cycle with a single
// shared compare unit, then decides, loading the first result into the
// output register; no new command is taken until the engine is idle again.
// An acquire that takes a slot out of the free queue then walks the queue
// one entry a cycle, over all the entries it holds (up to ENTRIES); a dirty
// victim emits a second result, the load request, before that walk. Flush
// walks all slots, one a cycle while the output register is free, emitting a
// write-back request for each dirty one, or a done result if none is dirty.
// s_axis_tready is high only while the engine is idle and its output register
// can take a result. Results are held in an output register; when the
// receiver stalls the engine waits with it. Reset empties the cache and
// queues slots 0..N-1.
// ----------------------------------------------------------------------------
module refcounted_block_cache_lru
  import rbc_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] operation, [34:3] block_number, [38:35] slot, zero fill
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] slot_out, [35:4] block_out, [36] hit, [37] is_dirty, zero fill
  output logic [39:0] m_axis_tdata,
  // kind
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  logic [BLOCK_BITS-1:0] tags [ENTRIES];
  logic [ENTRIES-1:0]    valid_bits, dirty_bits;
  logic [REF_BITS-1:0]   ref_counts [ENTRIES];
  logic [IW-1:0]         free_order [ENTRIES];
  logic [CW-1:0]         free_count, in_use_count;

  state_t state, state_next;
  logic [2:0]            op;
  logic [BLOCK_BITS-1:0] blk;
  logic [3:0]            slot_in;
  logic [CW-1:0]         idx;       // walk counter
  logic                  found;
  logic [IW-1:0]         fslot;
  logic [CW-1:0]         qpos;      // queue position being walked
  logic [IW-1:0]         qslot;     // slot to take out of the queue
  logic                  qseen;     // slot already passed in the queue walk
  logic                  any_wb;

  // pending second result (load after victim write-back)
  logic [2:0]  k2;
  logic [3:0]  s2;
  logic [31:0] b2;

  logic        ov;
  logic [2:0]  okind;
  logic [3:0]  oslot;
  logic [31:0] oblk;
  logic        ohit, odirty, olast;

  logic [IW-1:0]         wi;
  logic [31:0]           blk32;
  logic [BLOCK_BITS-1:0] blk_in;
  logic                  out_free;
  logic                  out_load;
  logic                  victim_wb;

  assign wi = idx[IW-1:0];
  assign blk_in = BLOCK_BITS'(s_axis_tdata[34:3]);
  assign out_free = !ov || m_axis_tready;
  assign victim_wb = valid_bits[free_order[0]] && dirty_bits[free_order[0]];
  assign out_load = out_free && ((state == ST_DECIDE) || (state == ST_EMIT2) ||
                    (state == ST_FLUSH && ((valid_bits[wi] && dirty_bits[wi]) ||
                     (idx == CW'(ENTRIES - 1) && !any_wb))));
  assign s_axis_tready = (state == ST_IDLE) && out_free;
  assign m_axis_tvalid = ov;
  assign m_axis_tuser  = okind;
  assign m_axis_tlast  = olast;
  assign m_axis_tdata  = {2'b00, odirty, ohit, oblk, oslot};

  always_comb begin
    blk32 = '0;
    for (int b = 0; b < 32; b++) begin
      if (b < BLOCK_BITS) blk32[b] = blk[b];
    end
  end

  function automatic logic [3:0] s4(input logic [IW-1:0] v);
    logic [3:0] r;
    r = '0;
    for (int b = 0; b < 4; b++) begin
      if (b < IW) r[b] = v[b];
    end
    return r;
  endfunction

  logic slot_ok;
  logic [IW-1:0] sidx;
  always_comb begin
    slot_ok = ({28'd0, slot_in} < 32'(ENTRIES));
    sidx = '0;
    for (int b = 0; b < IW; b++) begin
      if (b < 4) sidx[b] = slot_in[b];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          if (s_axis_tdata[2:0] == OP_FLUSH) state_next = ST_FLUSH;
          else state_next = ST_SCAN;
        end
      end
      ST_SCAN: if (idx == CW'(ENTRIES - 1)) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (out_free) begin
          if (op == OP_ACQUIRE && found && ref_counts[fslot] == '0)
            state_next = ST_SHIFT;
          else if (op == OP_ACQUIRE && !found && free_count != '0)
            state_next = victim_wb ? ST_EMIT2 : ST_SHIFT;
          else
            state_next = ST_IDLE;
        end
      end
      ST_SHIFT: if (qpos + 1'b1 >= free_count) state_next = ST_IDLE;
      ST_FLUSH: if (out_free && idx == CW'(ENTRIES - 1)) state_next = ST_IDLE;
      ST_EMIT2: if (out_free) state_next = ST_SHIFT;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid_bits <= '0;
      dirty_bits <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        tags[i] <= '0;
        ref_counts[i] <= '0;
        free_order[i] <= IW'(i);
      end
      free_count <= CW'(ENTRIES);
      in_use_count <= '0;
      ov <= 1'b0;
      idx <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) ov <= 1'b1;
      else if (m_axis_tready) ov <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            op <= s_axis_tdata[2:0];
            blk <= blk_in;
            slot_in <= s_axis_tdata[38:35];
            idx <= '0;
            found <= 1'b0;
            fslot <= '0;
            any_wb <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (!found && valid_bits[wi] && tags[wi] == blk) begin
            found <= 1'b1;
            fslot <= wi;
          end
          idx <= idx + 1'b1;
        end
        ST_FLUSH: begin
          if (out_free) begin
            if (valid_bits[wi] && dirty_bits[wi]) begin
              okind <= K_WB_REQ; oslot <= s4(wi);
              oblk <= 32'(tags[wi]); ohit <= 1'b1; odirty <= 1'b0;
              any_wb <= 1'b1;
              // last dirty slot at or after this one?
              olast <= ((dirty_bits & valid_bits) >> wi) == ENTRIES'(1);
            end else if (idx == CW'(ENTRIES - 1) && !any_wb) begin
              okind <= K_DONE; oslot <= '0; oblk <= '0;
              ohit <= 1'b0; odirty <= 1'b0; olast <= 1'b1;
            end
            valid_bits[wi] <= 1'b0;
            dirty_bits[wi] <= 1'b0;
            idx <= idx + 1'b1;
          end
        end
        ST_SHIFT: begin
          // pull entries one step forward once the removed one is passed
          if (qpos + 1'b1 < free_count) begin
            if (qseen || free_order[qpos[IW-1:0]] == qslot) begin
              free_order[qpos[IW-1:0]] <= free_order[IW'(qpos + 1'b1)];
              qseen <= 1'b1;
            end
            qpos <= qpos + 1'b1;
          end else begin
            free_count <= free_count - 1'b1;
          end
        end
        ST_EMIT2: begin
          if (out_free) begin
            okind <= k2; oslot <= s2; oblk <= b2;
            ohit <= 1'b0; odirty <= 1'b0; olast <= 1'b1;
          end
        end
        ST_DECIDE: begin
          if (out_free) begin
            case (op)
              OP_ACQUIRE: begin
                odirty <= 1'b0;
                qpos <= '0;
                qseen <= 1'b0;
                if (found) begin
                  okind <= K_DONE; oslot <= s4(fslot); oblk <= blk32; ohit <= 1'b1;
                  olast <= 1'b1;
                  qslot <= fslot;
                  if (ref_counts[fslot] != '1)
                    ref_counts[fslot] <= ref_counts[fslot] + 1'b1;
                  if (ref_counts[fslot] == '0)
                    in_use_count <= in_use_count + 1'b1;
                end else if (free_count == '0) begin
                  okind <= K_FULL; oslot <= '0; oblk <= blk32; ohit <= 1'b0;
                  olast <= 1'b1;
                end else begin
                  if (victim_wb) begin
                    okind <= K_WB_REQ; oslot <= s4(free_order[0]);
                    oblk <= 32'(tags[free_order[0]]);
                    olast <= 1'b0;
                  end else begin
                    okind <= K_LOAD_REQ; oslot <= s4(free_order[0]);
                    oblk <= blk32;
                    olast <= 1'b1;
                  end
                  ohit <= 1'b0;
                  qslot <= free_order[0];
                  k2 <= K_LOAD_REQ; s2 <= s4(free_order[0]); b2 <= blk32;
                  tags[free_order[0]] <= blk;
                  valid_bits[free_order[0]] <= 1'b1;
                  dirty_bits[free_order[0]] <= 1'b0;
                  ref_counts[free_order[0]] <= REF_BITS'(1);
                  in_use_count <= in_use_count + 1'b1;
                end
              end
              OP_RELEASE: begin
                odirty <= 1'b0; olast <= 1'b1;
                if (!slot_ok || ref_counts[sidx] == '0) begin
                  okind <= K_UNDERFLOW; oslot <= slot_in; oblk <= '0; ohit <= 1'b0;
                end else begin
                  okind <= K_DONE; oslot <= slot_in; oblk <= 32'(tags[sidx]);
                  ohit <= 1'b1;
                  ref_counts[sidx] <= ref_counts[sidx] - 1'b1;
                  if (ref_counts[sidx] == REF_BITS'(1)) begin
                    if (free_count < CW'(ENTRIES)) begin
                      free_order[free_count[IW-1:0]] <= sidx;
                      free_count <= free_count + 1'b1;
                    end
                    if (in_use_count != '0) in_use_count <= in_use_count - 1'b1;
                  end
                end
              end
              OP_WRITE_BACK: begin
                odirty <= 1'b0; olast <= 1'b1;
                oblk <= blk32; ohit <= found;
                oslot <= found ? s4(fslot) : 4'd0;
                if (found && dirty_bits[fslot]) begin
                  okind <= K_WB_REQ; dirty_bits[fslot] <= 1'b0;
                end else okind <= K_DONE;
              end
              OP_DIRTY_QRY: begin
                olast <= 1'b1;
                okind <= K_DONE; oblk <= blk32; ohit <= found;
                oslot <= found ? s4(fslot) : 4'd0;
                odirty <= found && dirty_bits[fslot];
              end
              OP_MARK_DIRTY: begin
                odirty <= 1'b0; olast <= 1'b1;
                okind <= K_DONE; oslot <= slot_in;
                if (slot_ok && valid_bits[sidx]) begin
                  dirty_bits[sidx] <= 1'b1; oblk <= 32'(tags[sidx]); ohit <= 1'b1;
                end else begin
                  oblk <= '0; ohit <= 1'b0;
                end
              end
              default: begin
                odirty <= 1'b0; olast <= 1'b1;
                okind <= K_DONE; oslot <= '0; oblk <= '0; ohit <= 1'b0;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> verif/tb_refcounted_block_cache_lru.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_refcounted_block_cache_lru
// Self-checking bench for the block cache tag engine. A behavioral copy of
// the slot table and the LRU free queue predicts every result of every
// command. Results are compared field by field in order as they arrive.
// ----------------------------------------------------------------------------
module tb_refcounted_block_cache_lru;
  import rbc_pkg::*;

  localparam int NSLOT     = 16;
  localparam int CYC_LIMIT = 400000;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  slot;
    logic [31:0] blk;
    logic        hit;
    logic        dirty;
    logic        last;
  } cache_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  refcounted_block_cache_lru u_top (.*);

  always #4 clk = ~clk;

  // shadow of the slot table
  logic [31:0] tag_q   [NSLOT];
  logic        valid_q [NSLOT];
  logic        dirty_q [NSLOT];
  logic [7:0]  refs_q  [NSLOT];
  logic [3:0]  lru_q   [$];

  cache_rsp_t  pending_rsp [$];
  int          err_cnt = 0;
  int          cmd_cnt = 0;
  int          rsp_cnt = 0;
  int          cyc_cnt = 0;
  bit          rx_hold = 1'b0;
  bit          no_idle = 1'b0;
  logic [31:0] recent_blk [$];

  function automatic int find_slot(logic [31:0] b);
    for (int i = 0; i < NSLOT; i++)
      if (valid_q[i] && tag_q[i] == b) return i;
    return -1;
  endfunction

  function automatic void push_rsp(kind_t k, int s, logic [31:0] b, logic h,
                                   logic d, logic l);
    cache_rsp_t r;
    r.kind = k; r.slot = s[3:0]; r.blk = b; r.hit = h; r.dirty = d; r.last = l;
    pending_rsp.push_back(r);
  endfunction

  function automatic void unlink_free(int s);
    foreach (lru_q[i])
      if (lru_q[i] == s) begin
        lru_q.delete(i);
        return;
      end
  endfunction

  function automatic void predict_cache(op_t op, logic [31:0] b, logic [3:0] s);
    int f;
    int v;
    int n;
    case (op)
      OP_ACQUIRE: begin
        f = find_slot(b);
        if (f >= 0) begin
          if (refs_q[f] == 0) unlink_free(f);
          if (refs_q[f] != 8'hFF) refs_q[f]++;
          push_rsp(K_DONE, f, b, 1, 0, 1);
        end else if (lru_q.size() == 0) begin
          push_rsp(K_FULL, 0, b, 0, 0, 1);
        end else begin
          v = lru_q.pop_front();
          if (valid_q[v] && dirty_q[v]) push_rsp(K_WB_REQ, v, tag_q[v], 0, 0, 0);
          tag_q[v] = b; valid_q[v] = 1; dirty_q[v] = 0; refs_q[v] = 1;
          push_rsp(K_LOAD_REQ, v, b, 0, 0, 1);
        end
      end
      OP_RELEASE: begin
        if (refs_q[s] == 0) begin
          push_rsp(K_UNDERFLOW, s, 0, 0, 0, 1);
        end else begin
          refs_q[s]--;
          if (refs_q[s] == 0) lru_q.push_back(s);
          push_rsp(K_DONE, s, tag_q[s], 1, 0, 1);
        end
      end
      OP_WRITE_BACK: begin
        f = find_slot(b);
        if (f >= 0 && dirty_q[f]) begin
          dirty_q[f] = 0;
          push_rsp(K_WB_REQ, f, b, 1, 0, 1);
        end else begin
          push_rsp(K_DONE, f >= 0 ? f : 0, b, f >= 0, 0, 1);
        end
      end
      OP_DIRTY_QRY: begin
        f = find_slot(b);
        if (f >= 0) push_rsp(K_DONE, f, b, 1, dirty_q[f], 1);
        else push_rsp(K_DONE, 0, b, 0, 0, 1);
      end
      OP_FLUSH: begin
        n = 0;
        for (int i = 0; i < NSLOT; i++) begin
          if (valid_q[i] && dirty_q[i]) begin
            push_rsp(K_WB_REQ, i, tag_q[i], 1, 0, 0);
            n++;
          end
          valid_q[i] = 0; dirty_q[i] = 0;
        end
        if (n == 0) push_rsp(K_DONE, 0, 0, 0, 0, 1);
        else pending_rsp[pending_rsp.size() - 1].last = 1'b1;
      end
      OP_MARK_DIRTY: begin
        if (valid_q[s]) begin
          dirty_q[s] = 1;
          push_rsp(K_DONE, s, tag_q[s], 1, 0, 1);
        end else begin
          push_rsp(K_DONE, s, 0, 0, 0, 1);
        end
      end
      default: push_rsp(K_DONE, 0, 0, 0, 0, 1);
    endcase
  endfunction

  // send one command; idles before it at random unless idling is off
  task automatic send_cmd(logic [2:0] op, logic [31:0] b, logic [3:0] s);
    while (!no_idle && $urandom_range(99) < 33) @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, s, b, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_cache(op_t'(op), b, s);
    cmd_cnt++;
    s_axis_tvalid <= 1'b0;
    // the engine is busy after a transaction
    @(posedge clk);
  endtask

  task automatic drain_all();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (rst) m_axis_tready <= 1'b0;
    else if (rx_hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 33);
  end

  always @(posedge clk) begin
    cache_rsp_t exp_r;
    cache_rsp_t got_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_r.kind  = kind_t'(m_axis_tuser);
      got_r.slot  = m_axis_tdata[3:0];
      got_r.blk   = m_axis_tdata[35:4];
      got_r.hit   = m_axis_tdata[36];
      got_r.dirty = m_axis_tdata[37];
      got_r.last  = m_axis_tlast;
      rsp_cnt++;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, got_r);
        err_cnt++;
      end else begin
        exp_r = pending_rsp.pop_front();
        if (got_r.kind !== exp_r.kind || got_r.slot !== exp_r.slot ||
            got_r.blk !== exp_r.blk || got_r.hit !== exp_r.hit ||
            got_r.dirty !== exp_r.dirty || got_r.last !== exp_r.last) begin
          $display("%0t: mismatch, expected %p actual %p", $time, exp_r, got_r);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk)
    if (cyc_cnt > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cyc_cnt);
      $display("status: fail");
      $finish;
    end

  task automatic test_directed();
    send_cmd(OP_RELEASE, 32'h0, 4'd0);               // underflow
    send_cmd(OP_DIRTY_QRY, 32'hFFFF_FFFF, 4'd0);     // miss
    send_cmd(OP_MARK_DIRTY, 32'h0, 4'd15);           // invalid slot
    send_cmd(OP_ACQUIRE, 32'h0, 4'd0);
    send_cmd(OP_ACQUIRE, 32'hFFFF_FFFF, 4'd0);
    send_cmd(OP_ACQUIRE, 32'h0, 4'hF);               // hit
    send_cmd(OP_MARK_DIRTY, 32'h0, 4'd1);
    send_cmd(OP_DIRTY_QRY, 32'hFFFF_FFFF, 4'd0);
    send_cmd(OP_WRITE_BACK, 32'hFFFF_FFFF, 4'd0);    // dirty write-back
    send_cmd(OP_WRITE_BACK, 32'hFFFF_FFFF, 4'd0);    // clean
    send_cmd(OP_WRITE_BACK, 32'h1234_5678, 4'd0);    // miss
    send_cmd(OP_RELEASE, 32'h0, 4'd1);               // back to the free queue
    send_cmd(3'd6, 32'hA5A5_A5A5, 4'hA);
    send_cmd(3'd7, 32'h5A5A_5A5A, 4'h5);
    send_cmd(OP_MARK_DIRTY, 32'h0, 4'd0);
    send_cmd(OP_FLUSH, 32'h0, 4'd0);                 // one write-back
    send_cmd(OP_FLUSH, 32'h0, 4'd0);                 // nothing dirty
    drain_all();
  endtask

  // fill every free slot, overflow, dirty them all, flush with 15 write-backs
  task automatic test_full_cache();
    for (int i = 0; i < NSLOT + 2; i++) send_cmd(OP_ACQUIRE, 32'h100 + i, 4'd0);
    for (int i = 0; i < NSLOT; i++) send_cmd(OP_MARK_DIRTY, 32'h0, i[3:0]);
    send_cmd(OP_FLUSH, 32'h0, 4'd0);
    drain_all();
  endtask

  // free every slot, count one block up back to back, then release it all
  task automatic test_ref_counting();
    logic [31:0] b;
    b = 32'h8000_0001;
    for (int s = 0; s < NSLOT; s++)
      while (refs_q[s] != 0) send_cmd(OP_RELEASE, 32'h0, s[3:0]);
    no_idle = 1'b1;
    for (int i = 0; i < 24; i++) send_cmd(OP_ACQUIRE, b, 4'd0);
    no_idle = 1'b0;
    drain_all();
    for (int s = 0; s < NSLOT; s++)
      while (refs_q[s] != 0) send_cmd(OP_RELEASE, 32'h0, s[3:0]);
    drain_all();
  endtask

  // receiver holds off while commands keep coming, so the engine stalls
  task automatic test_backpressure();
    rx_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_cmd(OP_ACQUIRE, 32'h200 + i % 5, 4'd0);
    join
    drain_all();
  endtask

  task automatic test_random();
    logic [2:0]  op;
    logic [31:0] b;
    logic [3:0]  s;
    int r;
    for (int i = 0; i < 130; i++) begin
      no_idle = (i >= 40 && i < 80);
      r = $urandom_range(99);
      if (r < 40) op = OP_ACQUIRE;
      else if (r < 65) op = OP_RELEASE;
      else if (r < 75) op = OP_MARK_DIRTY;
      else if (r < 84) op = OP_WRITE_BACK;
      else if (r < 93) op = OP_DIRTY_QRY;
      else if (r < 96) op = OP_FLUSH;
      else op = 3'($urandom_range(7));
      // reuse recent blocks so hits are common
      if (recent_blk.size() != 0 && $urandom_range(99) < 60)
        b = recent_blk[$urandom_range(recent_blk.size() - 1)];
      else begin
        b = $urandom();
        recent_blk.push_back(b);
        if (recent_blk.size() > 24) void'(recent_blk.pop_front());
      end
      s = 4'($urandom_range(15));
      if (op == OP_RELEASE && $urandom_range(99) < 70)
        for (int k = 0; k < NSLOT; k++)
          if (refs_q[(s + k) % NSLOT] != 0) begin
            s = 4'((s + k) % NSLOT);
            break;
          end
      send_cmd(op, b, s);
    end
    no_idle = 1'b0;
    drain_all();
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      tag_q[i] = '0; valid_q[i] = 0; dirty_q[i] = 0; refs_q[i] = '0;
      lru_q.push_back(i[3:0]);
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_cache();
    test_ref_counting();
    test_backpressure();
    test_random();
    $display("covered %0d commands and %0d results: all operations, full cache,",
             cmd_cnt, rsp_cnt);
    $display("reference counting, underflow, flushes and long receiver stalls");
    if (err_cnt == 0 && pending_rsp.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d errors, %0d results missing", err_cnt, pending_rsp.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
